[design/lct_pkg.sv]
// Shared constants, register codes and the log2 mantissa function for the
// color transfer pixel pipeline. No dependencies.
package lct_pkg;

    localparam int FRAC_BITS_DEF     = 12;
    localparam int LUT_ADDR_BITS_DEF = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PIX_W      = 8;

    // Configuration register codes.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_L       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ALPHA   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_BETA    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_L     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_ALPHA = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BETA  = 3'd5;

    localparam logic [CFG_DATA_W-1:0] GAIN_RESET = 16'd4096;

    localparam int LMS_W = 24;
    localparam int LIN_W = 26;
    localparam int MANT_W = 17;
    localparam logic [LIN_W-1:0] LMS_CAP = 26'd67108863;

    localparam logic [15:0] FWD_MAT [3][3] = '{
        '{16'd24976, 16'd37899, 16'd2635},
        '{16'd12891, 16'd47474, 16'd5125},
        '{16'd1579,  16'd8441,  16'd55339}
    };

    localparam logic signed [19:0] INV_MAT [3][3] = '{
        '{20'sd292808, -20'sd235097, 20'sd7818},
        '{-20'sd79862, 20'sd156035,  -20'sd10643},
        '{20'sd3257,   -20'sd15984,  20'sd78938}
    };

    localparam logic signed [16:0] LOG10_OF_2 = 17'sd19728;
    localparam logic signed [18:0] LOG2_OF_10 = 19'sd217706;
    localparam logic signed [16:0] INV_SQRT3  = 17'sd37836;
    localparam logic signed [16:0] INV_SQRT6  = 17'sd26755;
    localparam logic signed [16:0] INV_SQRT2  = 17'sd46341;

    // log2 of a Q16 mantissa in [1,2) by repeated squaring in Q30.
    function automatic logic [15:0] mant_log2(input logic [MANT_W-1:0] m);
        logic [63:0] y;
        logic [15:0] r;
        y = 64'(m) << 14;
        r = '0;
        for (int k = 0; k < 16; k++) begin
            y = (y * y) >> 30;
            r = {r[14:0], 1'b0};
            if (y >= 64'h8000_0000) begin
                y = y >> 1;
                r[0] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

[design/lab_color_transfer_pixel.sv]
// Top level of the color transfer pixel pipeline: RGB to l-alpha-beta,
// per-channel gain and offset, and back to RGB. Depends on lct_pkg.
//
//   channel   direction  handshake                 payload
//   cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//   pixel in  in         i_in_valid / o_in_ready   i_red_in, i_green_in, i_blue_in,
//                                                  i_frame_end_in
//   pixel out out        o_out_valid / i_out_ready o_red_out, o_green_out, o_blue_out,
//                                                  o_frame_end_out
//
// One item enters per cycle while o_in_ready is high; the pipeline has
// 14 register stages (two of them are the log and pow table reads).
// Reset clears the stage valid bits and loads the register reset values.
// Each stage holds only while it is full and the stage after it holds, so a
// stalled output still lets empty stages upstream fill. Configuration writes
// take effect at once and are always ready.
module lab_color_transfer_pixel #(
    parameter int FRAC_BITS     = lct_pkg::FRAC_BITS_DEF,
    parameter int LUT_ADDR_BITS = lct_pkg::LUT_ADDR_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lct_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lct_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [lct_pkg::PIX_W-1:0]        i_red_in,
    input  logic [lct_pkg::PIX_W-1:0]        i_green_in,
    input  logic [lct_pkg::PIX_W-1:0]        i_blue_in,
    input  logic                             i_frame_end_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [lct_pkg::PIX_W-1:0]        o_red_out,
    output logic [lct_pkg::PIX_W-1:0]        o_green_out,
    output logic [lct_pkg::PIX_W-1:0]        o_blue_out,
    output logic                             o_frame_end_out
);

    localparam int NS        = 14;
    localparam int LUT_DEPTH = 1 << LUT_ADDR_BITS;
    localparam int LMS_W     = lct_pkg::LMS_W;
    localparam int LIN_W     = lct_pkg::LIN_W;
    localparam int MANT_W    = lct_pkg::MANT_W;
    localparam int P_W       = 5;
    localparam int L2_W      = 23;
    localparam int LGP_W     = L2_W + 16;
    localparam int LG_W      = FRAC_BITS + 4;
    localparam int S_W       = FRAC_BITS + 6;
    localparam int SP_W      = S_W + 17;
    localparam int TP_W      = S_W + 17;
    localparam int Y_W       = TP_W - FRAC_BITS + 1;
    localparam int X_W       = FRAC_BITS + 5;
    localparam int AB_W      = X_W + 17;
    localparam int SUM_W     = AB_W + 2;
    localparam int V_W       = SUM_W - 16;
    localparam int VP_W      = V_W + 19;
    localparam int T_W       = VP_W - FRAC_BITS;
    localparam int N_W       = T_W - 16;
    localparam int RP_W      = LIN_W + 1 + 20;
    localparam int RS_W      = RP_W + 2;
    localparam int RGB_W     = RS_W - 32;
    localparam int PIX_W     = lct_pkg::PIX_W;

    localparam logic signed [LG_W-1:0] LG_FLOOR = LG_W'(-(5 <<< FRAC_BITS));
    localparam logic signed [V_W-1:0]  V_FLOOR  = V_W'(-(5 <<< FRAC_BITS));
    localparam logic signed [Y_W-1:0]  Y_MIN    = Y_W'(-(16 <<< FRAC_BITS));
    localparam logic signed [Y_W-1:0]  Y_MAX    = Y_W'((16 <<< FRAC_BITS) - 1);
    localparam logic signed [N_W-1:0]  N_SAT    = N_W'(10);
    localparam logic signed [N_W-1:0]  N_MIN    = N_W'(-32);
    localparam logic signed [RGB_W-1:0] RGB_MAX = RGB_W'(255);

    typedef logic [15:0]       t_log_rom [LUT_DEPTH];
    typedef logic [MANT_W-1:0] t_pow_rom [LUT_DEPTH];

    function automatic t_log_rom f_build_log();
        t_log_rom tab;
        for (int i = 0; i < LUT_DEPTH; i++) begin
            tab[i] = lct_pkg::mant_log2(MANT_W'(65536 + (i << (16 - LUT_ADDR_BITS))));
        end
        return tab;
    endfunction

    // Each pow2 entry is the largest mantissa whose log2 stays at or below the index.
    function automatic t_pow_rom f_build_pow();
        t_pow_rom          tab;
        logic [MANT_W-1:0] m;
        logic [MANT_W-1:0] cand;
        logic [15:0]       tgt;
        for (int i = 0; i < LUT_DEPTH; i++) begin
            tgt = 16'(i << (16 - LUT_ADDR_BITS));
            m   = MANT_W'(65536);
            for (int b = 15; b >= 0; b--) begin
                cand = m | (MANT_W'(1) << b);
                if (lct_pkg::mant_log2(cand) <= tgt) begin
                    m = cand;
                end
            end
            tab[i] = m;
        end
        return tab;
    endfunction

    localparam t_log_rom LOG_ROM = f_build_log();
    localparam t_pow_rom POW_ROM = f_build_pow();

    // Configuration registers.
    logic        [15:0] r_gain [3];
    logic signed [15:0] r_off  [3];

    // Pipeline control.
    logic [NS-1:0] r_vld;
    logic [NS-1:0] r_fe;
    logic [NS-1:0] en;

    // Stage registers and their next values.
    logic        [LMS_W-1:0]         r_lms  [3];
    logic        [LMS_W-1:0]         n_lms  [3];
    logic        [P_W-1:0]           r_p1   [3];
    logic        [P_W-1:0]           n_p    [3];
    logic        [LUT_ADDR_BITS-1:0] r_idx  [3];
    logic        [LUT_ADDR_BITS-1:0] n_idx  [3];
    logic        [LMS_W-1:0]         sh     [3];
    logic        [2:0]               r_z1;
    logic        [2:0]               n_z;
    logic        [15:0]              r_ent  [3];
    logic        [P_W-1:0]           r_p2   [3];
    logic        [2:0]               r_z2;
    logic signed [L2_W-1:0]          l2     [3];
    logic signed [LGP_W-1:0]         lgp    [3];
    logic signed [LG_W-1:0]          r_lg   [3];
    logic signed [LG_W-1:0]          n_lg   [3];
    logic signed [S_W-1:0]           s      [3];
    logic signed [SP_W-1:0]          sp     [3];
    logic signed [S_W-1:0]           r_lab  [3];
    logic signed [S_W-1:0]           n_lab  [3];
    logic signed [TP_W-1:0]          r_tp   [3];
    logic signed [TP_W-1:0]          n_tp   [3];
    logic signed [Y_W-1:0]           y      [3];
    logic signed [X_W-1:0]           r_x    [3];
    logic signed [X_W-1:0]           n_x    [3];
    logic signed [AB_W-1:0]          r_ab   [3];
    logic signed [AB_W-1:0]          n_ab   [3];
    logic signed [SUM_W-1:0]         sum    [3];
    logic signed [SUM_W-1:0]         sum_ab;
    logic signed [V_W-1:0]           r_v    [3];
    logic signed [V_W-1:0]           n_v    [3];
    logic        [2:0]               r_low8;
    logic        [2:0]               n_low;
    logic signed [VP_W-1:0]          vp     [3];
    logic signed [T_W-1:0]           r_t    [3];
    logic signed [T_W-1:0]           n_t    [3];
    logic        [2:0]               r_low9;
    logic signed [N_W-1:0]           r_n    [3];
    logic        [MANT_W-1:0]        r_m    [3];
    logic        [2:0]               r_low10;
    logic        [LIN_W-1:0]         r_lin  [3];
    logic        [LIN_W-1:0]         n_lin  [3];
    logic signed [N_W-1:0]           neg_n  [3];
    logic signed [RP_W-1:0]          r_pr   [3][3];
    logic signed [RP_W-1:0]          n_pr   [3][3];
    logic signed [RS_W-1:0]          rsum   [3];
    logic signed [RGB_W-1:0]         rsh    [3];
    logic        [PIX_W-1:0]         r_rgb  [3];
    logic        [PIX_W-1:0]         n_rgb  [3];
    logic        [PIX_W-1:0]         in_rgb [3];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain[0] <= lct_pkg::GAIN_RESET;
            r_gain[1] <= lct_pkg::GAIN_RESET;
            r_gain[2] <= lct_pkg::GAIN_RESET;
            r_off[0]  <= '0;
            r_off[1]  <= '0;
            r_off[2]  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lct_pkg::REG_GAIN_L:       r_gain[0] <= i_cfg_data;
                lct_pkg::REG_GAIN_ALPHA:   r_gain[1] <= i_cfg_data;
                lct_pkg::REG_GAIN_BETA:    r_gain[2] <= i_cfg_data;
                lct_pkg::REG_OFFSET_L:     r_off[0]  <= $signed(i_cfg_data);
                lct_pkg::REG_OFFSET_ALPHA: r_off[1]  <= $signed(i_cfg_data);
                lct_pkg::REG_OFFSET_BETA:  r_off[2]  <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // A stage may load when it is empty or when its contents move on.
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_in_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign in_rgb[0] = i_red_in;
    assign in_rgb[1] = i_green_in;
    assign in_rgb[2] = i_blue_in;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // Stage 0: RGB to LMS.
            n_lms[i] = LMS_W'(32'(lct_pkg::FWD_MAT[i][0]) * 32'(in_rgb[0])
                            + 32'(lct_pkg::FWD_MAT[i][1]) * 32'(in_rgb[1])
                            + 32'(lct_pkg::FWD_MAT[i][2]) * 32'(in_rgb[2]));

            // Stage 1: leading one and mantissa address.
            n_p[i] = '0;
            for (int k = 0; k < LMS_W; k++) begin
                if (r_lms[i][k]) begin
                    n_p[i] = P_W'(k);
                end
            end
            n_z[i] = (r_lms[i] == '0);
            if ({1'b0, n_p[i]} >= (P_W + 1)'(LUT_ADDR_BITS)) begin
                sh[i] = r_lms[i] >> (n_p[i] - P_W'(LUT_ADDR_BITS));
            end else begin
                sh[i] = r_lms[i] << (P_W'(LUT_ADDR_BITS) - n_p[i]);
            end
            n_idx[i] = sh[i][LUT_ADDR_BITS-1:0];

            // Stage 3: log2 to log10.
            l2[i]  = $signed({({2'b00, r_p2[i]} - 7'd16), 16'h0000})
                   + $signed({7'b0000000, r_ent[i]});
            lgp[i] = l2[i] * lct_pkg::LOG10_OF_2;
            n_lg[i] = r_z2[i] ? LG_FLOOR : LG_W'(lgp[i] >>> (32 - FRAC_BITS));

            // Stage 5: gain product.
            n_tp[i] = r_lab[i] * $signed({1'b0, r_gain[i]});

            // Stage 6: offset and saturation.
            y[i] = Y_W'(r_tp[i] >>> FRAC_BITS) + Y_W'(r_off[i]);
            if (y[i] < Y_MIN) begin
                n_x[i] = X_W'(Y_MIN);
            end else if (y[i] > Y_MAX) begin
                n_x[i] = X_W'(Y_MAX);
            end else begin
                n_x[i] = X_W'(y[i]);
            end

            // Stage 9: log10 to log2.
            vp[i] = r_v[i] * lct_pkg::LOG2_OF_10;
            n_t[i] = T_W'(vp[i] >>> FRAC_BITS);

            // Stage 11: pow2 scaling by the integer part.
            neg_n[i] = -r_n[i];
            if (r_low10[i]) begin
                n_lin[i] = LIN_W'(1);
            end else if (r_n[i] >= N_SAT) begin
                n_lin[i] = lct_pkg::LMS_CAP;
            end else if (!r_n[i][N_W-1]) begin
                n_lin[i] = LIN_W'(r_m[i]) << r_n[i][3:0];
            end else if (r_n[i] <= N_MIN) begin
                n_lin[i] = '0;
            end else begin
                n_lin[i] = LIN_W'(r_m[i] >> neg_n[i][4:0]);
            end

            // Stage 12: inverse matrix products.
            for (int j = 0; j < 3; j++) begin
                n_pr[i][j] = $signed({1'b0, r_lin[j]}) * lct_pkg::INV_MAT[i][j];
            end

            // Stage 13: sum, scale and clamp.
            rsum[i] = RS_W'(r_pr[i][0]) + RS_W'(r_pr[i][1]) + RS_W'(r_pr[i][2]);
            rsh[i]  = RGB_W'(rsum[i] >>> 32);
            if (rsh[i][RGB_W-1]) begin
                n_rgb[i] = '0;
            end else if (rsh[i] > RGB_MAX) begin
                n_rgb[i] = '1;
            end else begin
                n_rgb[i] = rsh[i][PIX_W-1:0];
            end
        end

        // Stage 4: forward l-alpha-beta.
        s[0] = S_W'(r_lg[0]) + S_W'(r_lg[1]) + S_W'(r_lg[2]);
        s[1] = S_W'(r_lg[0]) + S_W'(r_lg[1]) - (S_W'(r_lg[2]) <<< 1);
        s[2] = S_W'(r_lg[0]) - S_W'(r_lg[1]);
        sp[0] = s[0] * lct_pkg::INV_SQRT3;
        sp[1] = s[1] * lct_pkg::INV_SQRT6;
        sp[2] = s[2] * lct_pkg::INV_SQRT2;
        for (int i = 0; i < 3; i++) begin
            n_lab[i] = S_W'(sp[i] >>> 16);
        end

        // Stage 7: inverse l-alpha-beta products.
        n_ab[0] = r_x[0] * lct_pkg::INV_SQRT3;
        n_ab[1] = r_x[1] * lct_pkg::INV_SQRT6;
        n_ab[2] = r_x[2] * lct_pkg::INV_SQRT2;

        // Stage 8: inverse l-alpha-beta sums back to log LMS.
        sum_ab = SUM_W'(r_ab[0]) + SUM_W'(r_ab[1]);
        sum[0] = sum_ab + SUM_W'(r_ab[2]);
        sum[1] = sum_ab - SUM_W'(r_ab[2]);
        sum[2] = SUM_W'(r_ab[0]) - (SUM_W'(r_ab[1]) <<< 1);
        for (int i = 0; i < 3; i++) begin
            n_v[i]   = V_W'(sum[i] >>> 16);
            n_low[i] = (n_v[i] <= V_FLOOR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_fe[0] <= i_frame_end_in;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                r_fe[k] <= r_fe[k-1];
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (en[0]) begin
                r_lms[i] <= n_lms[i];
            end
            if (en[1]) begin
                r_p1[i]  <= n_p[i];
                r_idx[i] <= n_idx[i];
                r_z1[i]  <= n_z[i];
            end
            if (en[2]) begin
                r_ent[i] <= LOG_ROM[r_idx[i]];
                r_p2[i]  <= r_p1[i];
                r_z2[i]  <= r_z1[i];
            end
            if (en[3]) begin
                r_lg[i] <= n_lg[i];
            end
            if (en[4]) begin
                r_lab[i] <= n_lab[i];
            end
            if (en[5]) begin
                r_tp[i] <= n_tp[i];
            end
            if (en[6]) begin
                r_x[i] <= n_x[i];
            end
            if (en[7]) begin
                r_ab[i] <= n_ab[i];
            end
            if (en[8]) begin
                r_v[i]    <= n_v[i];
                r_low8[i] <= n_low[i];
            end
            if (en[9]) begin
                r_t[i]    <= n_t[i];
                r_low9[i] <= r_low8[i];
            end
            if (en[10]) begin
                r_n[i]     <= r_t[i][T_W-1:16];
                r_m[i]     <= POW_ROM[r_t[i][15 -: LUT_ADDR_BITS]];
                r_low10[i] <= r_low9[i];
            end
            if (en[11]) begin
                r_lin[i] <= n_lin[i];
            end
            if (en[12]) begin
                for (int j = 0; j < 3; j++) begin
                    r_pr[i][j] <= n_pr[i][j];
                end
            end
            if (en[13]) begin
                r_rgb[i] <= n_rgb[i];
            end
        end
    end

    assign o_out_valid     = r_vld[NS-1];
    assign o_red_out       = r_rgb[0];
    assign o_green_out     = r_rgb[1];
    assign o_blue_out      = r_rgb[2];
    assign o_frame_end_out = r_fe[NS-1];

    // The input side only stalls when every stage holds an item.
    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld))
        else $error("input stalled while a stage is empty");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

    a_item_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !(o_out_valid && i_out_ready))
        |=> ($countones(r_vld) == $past($countones(r_vld)) + 1))
        else $error("accepted item not counted in the pipeline");

    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(i_in_valid && o_in_ready) && o_out_valid && i_out_ready)
        |=> ($countones(r_vld) == $past($countones(r_vld)) - 1))
        else $error("delivered item not removed from the pipeline");

endmodule
